// ===== rtl/core/hlcs_pkg.sv =====
// package: types, constants, threshold tables and helper functions of the hold length sampler
`timescale 1ns / 1ps

package hlcs_pkg;

	localparam int unsigned NUM_THR = 19;
	localparam int unsigned HOLD_W = 5;
	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned RNG_W = 32;
	localparam int unsigned WCLS_W = 4;

	localparam logic [RNG_W-1:0] SEED_RESET = 32'd1;

	localparam logic KIND_FIRE = 1'b0;
	localparam logic KIND_JUMP = 1'b1;

	localparam logic [WCLS_W-1:0] WCLS_3 = 4'd3;
	localparam logic [WCLS_W-1:0] WCLS_4 = 4'd4;
	localparam logic [WCLS_W-1:0] WCLS_5 = 4'd5;
	localparam logic [WCLS_W-1:0] WCLS_6 = 4'd6;
	localparam logic [WCLS_W-1:0] WCLS_7 = 4'd7;
	localparam logic [WCLS_W-1:0] WCLS_8 = 4'd8;
	localparam logic [WCLS_W-1:0] WCLS_9 = 4'd9;
	localparam logic [WCLS_W-1:0] WCLS_10 = 4'd10;

	localparam logic [HOLD_W-1:0] HOLD_NONE = 5'd0;
	localparam logic [HOLD_W-1:0] HOLD_CONT_SLOW = 5'd3;
	localparam logic [HOLD_W-1:0] HOLD_CONT_FAST = 5'd1;

	typedef logic [SAMPLE_W-1:0] thr_tbl_t [NUM_THR];

	// cumulative thresholds, padded with the top value
	localparam thr_tbl_t THR_W3 = '{
		16'd21177, 16'd50622, 16'd61493, 16'd64460, 16'd65238, 16'd65450, 16'd65511,
		16'd65529, 16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535,
		16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535};
	localparam thr_tbl_t THR_W4 = '{
		16'd11988, 16'd30261, 16'd43975, 16'd52713, 16'd58074, 16'd61363, 16'd63407,
		16'd64701, 16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535,
		16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535};
	localparam thr_tbl_t THR_W5 = '{
		16'd8156, 16'd23263, 16'd36503, 16'd46045, 16'd52528, 16'd56869, 16'd59784,
		16'd61760, 16'd63115, 16'd64057, 16'd64721, 16'd65194, 16'd65535, 16'd65535,
		16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535};
	localparam thr_tbl_t THR_W8 = '{
		16'd10834, 16'd29162, 16'd43257, 16'd52190, 16'd57577, 16'd60808, 16'd62767,
		16'd63975, 16'd64734, 16'd65219, 16'd65535, 16'd65535, 16'd65535, 16'd65535,
		16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535};
	localparam thr_tbl_t THR_W9 = '{
		16'd8743, 16'd26625, 16'd41419, 16'd51014, 16'd56804, 16'd60241, 16'd62290,
		16'd63529, 16'd64290, 16'd64766, 16'd65068, 16'd65263, 16'd65392, 16'd65477,
		16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535};
	localparam thr_tbl_t THR_JUMP = '{
		16'd11323, 16'd29206, 16'd42761, 16'd51399, 16'd56679, 16'd59899, 16'd61889,
		16'd63139, 16'd63939, 16'd64461, 16'd64807, 16'd65040, 16'd65200, 16'd65311,
		16'd65389, 16'd65444, 16'd65484, 16'd65514, 16'd65535};

	typedef enum logic [3:0] {
		OP_ZERO,
		OP_CONT_SLOW,
		OP_CONT_FAST,
		OP_W3,
		OP_W4,
		OP_W5,
		OP_W8,
		OP_W9,
		OP_JUMP
	} op_t;

	function automatic op_t decode_op(logic kind, logic [WCLS_W-1:0] weapon);
		op_t op;
		op = OP_ZERO;
		if (kind == KIND_JUMP) begin
			op = OP_JUMP;
		end else begin
			case (weapon)
				WCLS_3: op = OP_W3;
				WCLS_4: op = OP_W4;
				WCLS_5: op = OP_W5;
				WCLS_8: op = OP_W8;
				WCLS_9: op = OP_W9;
				WCLS_6: op = OP_CONT_SLOW;
				WCLS_7: op = OP_CONT_SLOW;
				WCLS_10: op = OP_CONT_FAST;
				default: op = OP_ZERO;
			endcase
		end
		return op;
	endfunction

	function automatic logic op_draws(op_t op);
		logic d;
		case (op)
			OP_ZERO: d = 1'b0;
			OP_CONT_SLOW: d = 1'b0;
			OP_CONT_FAST: d = 1'b0;
			default: d = 1'b1;
		endcase
		return d;
	endfunction

	function automatic logic [RNG_W-1:0] xorshift32(logic [RNG_W-1:0] s);
		logic [RNG_W-1:0] a;
		logic [RNG_W-1:0] b;
		a = s ^ (s << 13);
		b = a ^ (a >> 17);
		return b ^ (b << 5);
	endfunction

endpackage

// ===== rtl/core/hlcs_if.sv =====
// interfaces: request and response channels of the hold length sampler
`timescale 1ns / 1ps

interface hlcs_req_if;
	logic valid;
	logic ready;
	logic kind;
	logic [hlcs_pkg::WCLS_W-1:0] weapon;

	modport source(output valid, output kind, output weapon, input ready);
	modport sink(input valid, input kind, input weapon, output ready);
endinterface

interface hlcs_rsp_if;
	logic valid;
	logic ready;
	logic [hlcs_pkg::HOLD_W-1:0] hold_frames;

	modport source(output valid, output hold_frames, input ready);
	modport sink(input valid, input hold_frames, output ready);
endinterface

// ===== rtl/core/hlcs_rng.sv =====
// module: xorshift32 generator state with seed load
`timescale 1ns / 1ps

module hlcs_rng (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [hlcs_pkg::RNG_W-1:0]      cfg_wdata,
	input  logic                            draw,
	output logic [hlcs_pkg::SAMPLE_W-1:0]   sample,
	output logic [hlcs_pkg::RNG_W-1:0]      state
);

	logic [hlcs_pkg::RNG_W-1:0] rng_q;
	logic [hlcs_pkg::RNG_W-1:0] rng_next;

	assign rng_next = hlcs_pkg::xorshift32(rng_q);
	assign sample = rng_next[hlcs_pkg::SAMPLE_W-1:0];
	assign state = rng_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rng_q <= hlcs_pkg::SEED_RESET;
		end else if (cfg_we) begin
			rng_q <= cfg_wdata;
		end else if (draw) begin
			rng_q <= rng_next;
		end
	end

endmodule

// ===== rtl/core/hlcs_lookup.sv =====
// module: threshold compare and first-match select giving the hold length
`timescale 1ns / 1ps

module hlcs_lookup (
	input  hlcs_pkg::op_t                   op,
	input  logic [hlcs_pkg::SAMPLE_W-1:0]   sample,
	output logic [hlcs_pkg::HOLD_W-1:0]     hold
);

	hlcs_pkg::thr_tbl_t tbl;
	logic [hlcs_pkg::HOLD_W-1:0] pos;

	always_comb begin
		case (op)
			hlcs_pkg::OP_W3: tbl = hlcs_pkg::THR_W3;
			hlcs_pkg::OP_W4: tbl = hlcs_pkg::THR_W4;
			hlcs_pkg::OP_W5: tbl = hlcs_pkg::THR_W5;
			hlcs_pkg::OP_W8: tbl = hlcs_pkg::THR_W8;
			hlcs_pkg::OP_W9: tbl = hlcs_pkg::THR_W9;
			default: tbl = hlcs_pkg::THR_JUMP;
		endcase
	end

	// first threshold not below the sample
	always_comb begin
		pos = hlcs_pkg::HOLD_W'(hlcs_pkg::NUM_THR);
		for (int i = hlcs_pkg::NUM_THR - 1; i >= 0; i--) begin
			if (sample <= tbl[i]) begin
				pos = hlcs_pkg::HOLD_W'(i + 1);
			end
		end
	end

	always_comb begin
		case (op)
			hlcs_pkg::OP_ZERO: hold = hlcs_pkg::HOLD_NONE;
			hlcs_pkg::OP_CONT_SLOW: hold = hlcs_pkg::HOLD_CONT_SLOW;
			hlcs_pkg::OP_CONT_FAST: hold = hlcs_pkg::HOLD_CONT_FAST;
			default: hold = pos;
		endcase
	end

endmodule

// ===== rtl/core/hold_length_cdf_sampler_core.sv =====
// top level: hold length sampler with request register, lookup and response register
`timescale 1ns / 1ps

// Hold length sampler. Each request item (kind, weapon) yields one response item with
// hold_frames. Jump requests and fire requests for classes 3, 4, 5, 8 and 9 advance the
// xorshift32 generator and map its low 16 bits through a cumulative threshold table;
// classes 6 and 7 give 3, class 10 gives 1, other ids give 0 and leave the generator alone.
// One item is accepted every cycle unless a low rsp.ready stalls the output; each response
// passes through the request register, then the response register after the threshold compare.
// The generator advances in the accept cycle, so back-to-back draws need no stall.
// Writing cfg_wdata with cfg_we loads the generator; reset loads 1. Write only while idle.

module hold_length_cdf_sampler_core (
	input  logic                        clk,
	input  logic                        arst_n,
	hlcs_req_if.sink                    req,
	hlcs_rsp_if.source                  rsp,
	input  logic                        cfg_we,
	input  logic [hlcs_pkg::RNG_W-1:0]  cfg_wdata
);

	logic in_acc;
	logic draw;
	logic adv_s1;
	logic out_free;
	hlcs_pkg::op_t in_op;
	logic [hlcs_pkg::SAMPLE_W-1:0] sample;
	logic [hlcs_pkg::RNG_W-1:0] rng_state;

	logic valid_s1;
	hlcs_pkg::op_t op_s1;
	logic [hlcs_pkg::SAMPLE_W-1:0] sample_s1;

	logic valid_s2;
	logic [hlcs_pkg::HOLD_W-1:0] hold_s2;
	logic [hlcs_pkg::HOLD_W-1:0] hold;

	assign out_free = !valid_s2 || rsp.ready;
	assign adv_s1 = valid_s1 && out_free;
	assign req.ready = !valid_s1 || out_free;
	assign in_acc = req.valid && req.ready;
	assign in_op = hlcs_pkg::decode_op(req.kind, req.weapon);
	assign draw = in_acc && hlcs_pkg::op_draws(in_op);

	hlcs_rng u_rng (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.draw      (draw),
		.sample    (sample),
		.state     (rng_state)
	);

	hlcs_lookup u_lookup (
		.op     (op_s1),
		.sample (sample_s1),
		.hold   (hold)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (out_free) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_s1 <= in_op;
			sample_s1 <= sample;
		end
		if (adv_s1) begin
			hold_s2 <= hold;
		end
	end

	assign rsp.valid = valid_s2;
	assign rsp.hold_frames = hold_s2;

`ifndef SYNTH
	a_seed_load: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> rng_state == $past(cfg_wdata))
		else $error("generator did not take the seed");

	a_no_draw_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !hlcs_pkg::op_draws(in_op) && !cfg_we) |=> rng_state == $past(rng_state))
		else $error("generator moved on a non-drawing item");

	a_draw_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && hlcs_pkg::op_draws(op_s1)) |=> hold_s2 != hlcs_pkg::HOLD_NONE)
		else $error("drawn hold length is zero");

	a_hold_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> hold_s2 <= hlcs_pkg::HOLD_W'(hlcs_pkg::NUM_THR))
		else $error("hold length out of range");
`endif

endmodule
